### rtl/kupyna_hash_engine_defines.svh
// Assertion macros for the hash engine.
`ifndef KUPYNA_HASH_ENGINE_DEFINES_SVH
`define KUPYNA_HASH_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KHE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define KHE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/kupyna_pkg.sv
// Shared constants, tables, types and field math for the hash engine.
package kupyna_pkg;

  localparam int MAX_COLUMNS = 16;
  localparam int SMALL_COLUMNS = 8;
  localparam int SMALL_ROUNDS = 10;
  localparam int LARGE_ROUNDS = 14;
  localparam logic [9:0] HASH_BITS_RESET = 10'd256;
  localparam logic [9:0] SMALL_LIMIT = 10'd256;
  localparam logic [63:0] Q_CONST = 64'h00F0F0F0F0F0F0F3;
  localparam int LEN_BITS = 97;

  localparam logic [7:0] MDS_ROW [8] = '{8'h01, 8'h01, 8'h05, 8'h01,
                                         8'h08, 8'h06, 8'h07, 8'h04};

  localparam logic [7:0] SBOX [4][256] = '{
    '{8'ha8,8'h43,8'h5f,8'h06,8'h6b,8'h75,8'h6c,8'h59,8'h71,8'hdf,8'h87,8'h95,8'h17,8'hf0,8'hd8,8'h09,
      8'h6d,8'hf3,8'h1d,8'hcb,8'hc9,8'h4d,8'h2c,8'haf,8'h79,8'he0,8'h97,8'hfd,8'h6f,8'h4b,8'h45,8'h39,
      8'h3e,8'hdd,8'ha3,8'h4f,8'hb4,8'hb6,8'h9a,8'h0e,8'h1f,8'hbf,8'h15,8'he1,8'h49,8'hd2,8'h93,8'hc6,
      8'h92,8'h72,8'h9e,8'h61,8'hd1,8'h63,8'hfa,8'hee,8'hf4,8'h19,8'hd5,8'had,8'h58,8'ha4,8'hbb,8'ha1,
      8'hdc,8'hf2,8'h83,8'h37,8'h42,8'he4,8'h7a,8'h32,8'h9c,8'hcc,8'hab,8'h4a,8'h8f,8'h6e,8'h04,8'h27,
      8'h2e,8'he7,8'he2,8'h5a,8'h96,8'h16,8'h23,8'h2b,8'hc2,8'h65,8'h66,8'h0f,8'hbc,8'ha9,8'h47,8'h41,
      8'h34,8'h48,8'hfc,8'hb7,8'h6a,8'h88,8'ha5,8'h53,8'h86,8'hf9,8'h5b,8'hdb,8'h38,8'h7b,8'hc3,8'h1e,
      8'h22,8'h33,8'h24,8'h28,8'h36,8'hc7,8'hb2,8'h3b,8'h8e,8'h77,8'hba,8'hf5,8'h14,8'h9f,8'h08,8'h55,
      8'h9b,8'h4c,8'hfe,8'h60,8'h5c,8'hda,8'h18,8'h46,8'hcd,8'h7d,8'h21,8'hb0,8'h3f,8'h1b,8'h89,8'hff,
      8'heb,8'h84,8'h69,8'h3a,8'h9d,8'hd7,8'hd3,8'h70,8'h67,8'h40,8'hb5,8'hde,8'h5d,8'h30,8'h91,8'hb1,
      8'h78,8'h11,8'h01,8'he5,8'h00,8'h68,8'h98,8'ha0,8'hc5,8'h02,8'ha6,8'h74,8'h2d,8'h0b,8'ha2,8'h76,
      8'hb3,8'hbe,8'hce,8'hbd,8'hae,8'he9,8'h8a,8'h31,8'h1c,8'hec,8'hf1,8'h99,8'h94,8'haa,8'hf6,8'h26,
      8'h2f,8'hef,8'he8,8'h8c,8'h35,8'h03,8'hd4,8'h7f,8'hfb,8'h05,8'hc1,8'h5e,8'h90,8'h20,8'h3d,8'h82,
      8'hf7,8'hea,8'h0a,8'h0d,8'h7e,8'hf8,8'h50,8'h1a,8'hc4,8'h07,8'h57,8'hb8,8'h3c,8'h62,8'he3,8'hc8,
      8'hac,8'h52,8'h64,8'h10,8'hd0,8'hd9,8'h13,8'h0c,8'h12,8'h29,8'h51,8'hb9,8'hcf,8'hd6,8'h73,8'h8d,
      8'h81,8'h54,8'hc0,8'hed,8'h4e,8'h44,8'ha7,8'h2a,8'h85,8'h25,8'he6,8'hca,8'h7c,8'h8b,8'h56,8'h80},
    '{8'hce,8'hbb,8'heb,8'h92,8'hea,8'hcb,8'h13,8'hc1,8'he9,8'h3a,8'hd6,8'hb2,8'hd2,8'h90,8'h17,8'hf8,
      8'h42,8'h15,8'h56,8'hb4,8'h65,8'h1c,8'h88,8'h43,8'hc5,8'h5c,8'h36,8'hba,8'hf5,8'h57,8'h67,8'h8d,
      8'h31,8'hf6,8'h64,8'h58,8'h9e,8'hf4,8'h22,8'haa,8'h75,8'h0f,8'h02,8'hb1,8'hdf,8'h6d,8'h73,8'h4d,
      8'h7c,8'h26,8'h2e,8'hf7,8'h08,8'h5d,8'h44,8'h3e,8'h9f,8'h14,8'hc8,8'hae,8'h54,8'h10,8'hd8,8'hbc,
      8'h1a,8'h6b,8'h69,8'hf3,8'hbd,8'h33,8'hab,8'hfa,8'hd1,8'h9b,8'h68,8'h4e,8'h16,8'h95,8'h91,8'hee,
      8'h4c,8'h63,8'h8e,8'h5b,8'hcc,8'h3c,8'h19,8'ha1,8'h81,8'h49,8'h7b,8'hd9,8'h6f,8'h37,8'h60,8'hca,
      8'he7,8'h2b,8'h48,8'hfd,8'h96,8'h45,8'hfc,8'h41,8'h12,8'h0d,8'h79,8'he5,8'h89,8'h8c,8'he3,8'h20,
      8'h30,8'hdc,8'hb7,8'h6c,8'h4a,8'hb5,8'h3f,8'h97,8'hd4,8'h62,8'h2d,8'h06,8'ha4,8'ha5,8'h83,8'h5f,
      8'h2a,8'hda,8'hc9,8'h00,8'h7e,8'ha2,8'h55,8'hbf,8'h11,8'hd5,8'h9c,8'hcf,8'h0e,8'h0a,8'h3d,8'h51,
      8'h7d,8'h93,8'h1b,8'hfe,8'hc4,8'h47,8'h09,8'h86,8'h0b,8'h8f,8'h9d,8'h6a,8'h07,8'hb9,8'hb0,8'h98,
      8'h18,8'h32,8'h71,8'h4b,8'hef,8'h3b,8'h70,8'ha0,8'he4,8'h40,8'hff,8'hc3,8'ha9,8'he6,8'h78,8'hf9,
      8'h8b,8'h46,8'h80,8'h1e,8'h38,8'he1,8'hb8,8'ha8,8'he0,8'h0c,8'h23,8'h76,8'h1d,8'h25,8'h24,8'h05,
      8'hf1,8'h6e,8'h94,8'h28,8'h9a,8'h84,8'he8,8'ha3,8'h4f,8'h77,8'hd3,8'h85,8'he2,8'h52,8'hf2,8'h82,
      8'h50,8'h7a,8'h2f,8'h74,8'h53,8'hb3,8'h61,8'haf,8'h39,8'h35,8'hde,8'hcd,8'h1f,8'h99,8'hac,8'had,
      8'h72,8'h2c,8'hdd,8'hd0,8'h87,8'hbe,8'h5e,8'ha6,8'hec,8'h04,8'hc6,8'h03,8'h34,8'hfb,8'hdb,8'h59,
      8'hb6,8'hc2,8'h01,8'hf0,8'h5a,8'hed,8'ha7,8'h66,8'h21,8'h7f,8'h8a,8'h27,8'hc7,8'hc0,8'h29,8'hd7},
    '{8'h93,8'hd9,8'h9a,8'hb5,8'h98,8'h22,8'h45,8'hfc,8'hba,8'h6a,8'hdf,8'h02,8'h9f,8'hdc,8'h51,8'h59,
      8'h4a,8'h17,8'h2b,8'hc2,8'h94,8'hf4,8'hbb,8'ha3,8'h62,8'he4,8'h71,8'hd4,8'hcd,8'h70,8'h16,8'he1,
      8'h49,8'h3c,8'hc0,8'hd8,8'h5c,8'h9b,8'had,8'h85,8'h53,8'ha1,8'h7a,8'hc8,8'h2d,8'he0,8'hd1,8'h72,
      8'ha6,8'h2c,8'hc4,8'he3,8'h76,8'h78,8'hb7,8'hb4,8'h09,8'h3b,8'h0e,8'h41,8'h4c,8'hde,8'hb2,8'h90,
      8'h25,8'ha5,8'hd7,8'h03,8'h11,8'h00,8'hc3,8'h2e,8'h92,8'hef,8'h4e,8'h12,8'h9d,8'h7d,8'hcb,8'h35,
      8'h10,8'hd5,8'h4f,8'h9e,8'h4d,8'ha9,8'h55,8'hc6,8'hd0,8'h7b,8'h18,8'h97,8'hd3,8'h36,8'he6,8'h48,
      8'h56,8'h81,8'h8f,8'h77,8'hcc,8'h9c,8'hb9,8'he2,8'hac,8'hb8,8'h2f,8'h15,8'ha4,8'h7c,8'hda,8'h38,
      8'h1e,8'h0b,8'h05,8'hd6,8'h14,8'h6e,8'h6c,8'h7e,8'h66,8'hfd,8'hb1,8'he5,8'h60,8'haf,8'h5e,8'h33,
      8'h87,8'hc9,8'hf0,8'h5d,8'h6d,8'h3f,8'h88,8'h8d,8'hc7,8'hf7,8'h1d,8'he9,8'hec,8'hed,8'h80,8'h29,
      8'h27,8'hcf,8'h99,8'ha8,8'h50,8'h0f,8'h37,8'h24,8'h28,8'h30,8'h95,8'hd2,8'h3e,8'h5b,8'h40,8'h83,
      8'hb3,8'h69,8'h57,8'h1f,8'h07,8'h1c,8'h8a,8'hbc,8'h20,8'heb,8'hce,8'h8e,8'hab,8'hee,8'h31,8'ha2,
      8'h73,8'hf9,8'hca,8'h3a,8'h1a,8'hfb,8'h0d,8'hc1,8'hfe,8'hfa,8'hf2,8'h6f,8'hbd,8'h96,8'hdd,8'h43,
      8'h52,8'hb6,8'h08,8'hf3,8'hae,8'hbe,8'h19,8'h89,8'h32,8'h26,8'hb0,8'hea,8'h4b,8'h64,8'h84,8'h82,
      8'h6b,8'hf5,8'h79,8'hbf,8'h01,8'h5f,8'h75,8'h63,8'h1b,8'h23,8'h3d,8'h68,8'h2a,8'h65,8'he8,8'h91,
      8'hf6,8'hff,8'h13,8'h58,8'hf1,8'h47,8'h0a,8'h7f,8'hc5,8'ha7,8'he7,8'h61,8'h5a,8'h06,8'h46,8'h44,
      8'h42,8'h04,8'ha0,8'hdb,8'h39,8'h86,8'h54,8'haa,8'h8c,8'h34,8'h21,8'h8b,8'hf8,8'h0c,8'h74,8'h67},
    '{8'h68,8'h8d,8'hca,8'h4d,8'h73,8'h4b,8'h4e,8'h2a,8'hd4,8'h52,8'h26,8'hb3,8'h54,8'h1e,8'h19,8'h1f,
      8'h22,8'h03,8'h46,8'h3d,8'h2d,8'h4a,8'h53,8'h83,8'h13,8'h8a,8'hb7,8'hd5,8'h25,8'h79,8'hf5,8'hbd,
      8'h58,8'h2f,8'h0d,8'h02,8'hed,8'h51,8'h9e,8'h11,8'hf2,8'h3e,8'h55,8'h5e,8'hd1,8'h16,8'h3c,8'h66,
      8'h70,8'h5d,8'hf3,8'h45,8'h40,8'hcc,8'he8,8'h94,8'h56,8'h08,8'hce,8'h1a,8'h3a,8'hd2,8'he1,8'hdf,
      8'hb5,8'h38,8'h6e,8'h0e,8'he5,8'hf4,8'hf9,8'h86,8'he9,8'h4f,8'hd6,8'h85,8'h23,8'hcf,8'h32,8'h99,
      8'h31,8'h14,8'hae,8'hee,8'hc8,8'h48,8'hd3,8'h30,8'ha1,8'h92,8'h41,8'hb1,8'h18,8'hc4,8'h2c,8'h71,
      8'h72,8'h44,8'h15,8'hfd,8'h37,8'hbe,8'h5f,8'haa,8'h9b,8'h88,8'hd8,8'hab,8'h89,8'h9c,8'hfa,8'h60,
      8'hea,8'hbc,8'h62,8'h0c,8'h24,8'ha6,8'ha8,8'hec,8'h67,8'h20,8'hdb,8'h7c,8'h28,8'hdd,8'hac,8'h5b,
      8'h34,8'h7e,8'h10,8'hf1,8'h7b,8'h8f,8'h63,8'ha0,8'h05,8'h9a,8'h43,8'h77,8'h21,8'hbf,8'h27,8'h09,
      8'hc3,8'h9f,8'hb6,8'hd7,8'h29,8'hc2,8'heb,8'hc0,8'ha4,8'h8b,8'h8c,8'h1d,8'hfb,8'hff,8'hc1,8'hb2,
      8'h97,8'h2e,8'hf8,8'h65,8'hf6,8'h75,8'h07,8'h04,8'h49,8'h33,8'he4,8'hd9,8'hb9,8'hd0,8'h42,8'hc7,
      8'h6c,8'h90,8'h00,8'h8e,8'h6f,8'h50,8'h01,8'hc5,8'hda,8'h47,8'h3f,8'hcd,8'h69,8'ha2,8'he2,8'h7a,
      8'ha7,8'hc6,8'h93,8'h0f,8'h0a,8'h06,8'he6,8'h2b,8'h96,8'ha3,8'h1c,8'haf,8'h6a,8'h12,8'h84,8'h39,
      8'he7,8'hb0,8'h82,8'hf7,8'hfe,8'h9d,8'h87,8'h5c,8'h81,8'h35,8'hde,8'hb4,8'ha5,8'hfc,8'h80,8'hef,
      8'hcb,8'hbb,8'h6b,8'h76,8'hba,8'h5a,8'h7d,8'h78,8'h0b,8'h95,8'he3,8'had,8'h74,8'h98,8'h3b,8'h36,
      8'h64,8'h6d,8'hdc,8'hf0,8'h59,8'ha9,8'h4c,8'h17,8'h7f,8'h91,8'hb8,8'hc9,8'h57,8'h1b,8'he0,8'h61}
  };

  typedef struct packed {
    logic       word_acc;
    logic       load;
    logic       blk;
    logic       pad;
    logic       round;
    logic       tload;
    logic       fold;
    logic       use_q;
    logic       clr_index;
    logic       restart;
    logic [3:0] rnd;
    logic [5:0] byte_idx;
  } kupyna_cmd_t;

  typedef struct packed {
    logic       wide;
    logic       full;
    logic       two_blocks;
    logic [6:0] hb;
  } kupyna_status_t;

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] x;
    r = 8'd0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = x[7] ? ((x << 1) ^ 8'h1D) : (x << 1);
    end
    return r;
  endfunction

endpackage

### rtl/kupyna_hash_engine.sv
// Top level of the Kupyna hash engine: controller plus datapath.
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------
//   config   | cfg_wen             | cfg_wdata (hash_bits)
//   input    | in_valid / in_stall | data_word, valid_bits, last_word
//   output   | out_valid/out_stall | digest_byte, last_byte
//
// A word that does not close a block is only stored. One that fills a block
// runs a compression of R rounds (R = 10 or 14, one round of P and Q per
// cycle). The last word runs one or two compressions, then the output
// transform, then one digest byte per cycle while out_stall is low.
// Synchronous reset restores a 256-bit hash length and the initial state.
`include "kupyna_hash_engine_defines.svh"
module kupyna_hash_engine #(
  parameter int MAX_COLUMNS = kupyna_pkg::MAX_COLUMNS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_word,
  input  logic [6:0]  valid_bits,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  digest_byte,
  output logic        last_byte
);

  kupyna_pkg::kupyna_cmd_t    cmd;
  kupyna_pkg::kupyna_status_t status;

  kupyna_ctrl #(.MC(MAX_COLUMNS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_word (last_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .last_byte (last_byte),
    .status    (status),
    .cmd       (cmd)
  );

  kupyna_dp #(.MC(MAX_COLUMNS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .data_word   (data_word),
    .valid_bits  (valid_bits),
    .last_word   (last_word),
    .cmd         (cmd),
    .status      (status),
    .digest_byte (digest_byte)
  );

  `KHE_ASSERT_NOW(a_no_intake_while_emit, out_valid, in_stall, "word taken during digest output")
  `KHE_ASSERT_NEXT(a_last_word_blocks, in_valid && !in_stall && last_word, in_stall && !out_valid, "engine idle after last word")
  `KHE_ASSERT_NEXT(a_done_after_last_byte, out_valid && !out_stall && last_byte, !out_valid && !in_stall, "output kept after final byte")

endmodule

### rtl/kupyna_round.sv
// One round of the P or Q permutation over all columns.
module kupyna_round #(
  parameter int MC = kupyna_pkg::MAX_COLUMNS
) (
  input  logic [MC-1:0][63:0] s_in,
  input  logic                wide,
  input  logic                use_q,
  input  logic [3:0]          rnd,
  output logic [MC-1:0][63:0] s_out
);

  localparam int LSH7 = (MC == 16) ? 11 : 7;

  logic [MC-1:0][7:0]      qb;
  logic [MC-1:0][63:0]     ak;
  logic [MC-1:0][7:0][7:0] sb;
  logic [MC-1:0][7:0][7:0] sh;

  always_comb begin
    for (int j = 0; j < MC; j++) begin
      qb[j] = wide ? (8'((MC - j - 1) * 16) ^ {4'd0, rnd})
                   : (8'((kupyna_pkg::SMALL_COLUMNS - j - 1) * 16) ^ {4'd0, rnd});
      if (use_q) begin
        ak[j] = s_in[j] + (kupyna_pkg::Q_CONST ^ {qb[j], 56'd0});
      end else begin
        ak[j] = s_in[j] ^ {56'd0, 8'(j * 16) ^ {4'd0, rnd}};
      end
      for (int i = 0; i < 8; i++) begin
        sb[j][i] = kupyna_pkg::SBOX[i & 3][ak[j][8*i +: 8]];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MC; j++) begin
      for (int i = 0; i < 8; i++) begin
        if (wide) begin
          sh[j][i] = sb[(j + MC - ((i == 7) ? LSH7 : i)) % MC][i];
        end else if (j < kupyna_pkg::SMALL_COLUMNS) begin
          sh[j][i] = sb[(j + 8 - i) & 7][i];
        end else begin
          sh[j][i] = sb[j][i];
        end
      end
    end
  end

  always_comb begin
    s_out = '0;
    for (int j = 0; j < MC; j++) begin
      for (int i = 0; i < 8; i++) begin
        for (int k = 0; k < 8; k++) begin
          s_out[j][8*i +: 8] = s_out[j][8*i +: 8]
                             ^ kupyna_pkg::gf_mul(sh[j][k], kupyna_pkg::MDS_ROW[(k + 8 - i) & 7]);
        end
      end
    end
  end

endmodule

### rtl/kupyna_dp.sv
// Datapath: chaining value, block buffer, padding, P and Q state, digest select.
module kupyna_dp #(
  parameter int MC = kupyna_pkg::MAX_COLUMNS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wen,
  input  logic [9:0]                 cfg_wdata,
  input  logic [63:0]                data_word,
  input  logic [6:0]                 valid_bits,
  input  logic                       last_word,
  input  kupyna_pkg::kupyna_cmd_t    cmd,
  output kupyna_pkg::kupyna_status_t status,
  output logic [7:0]                 digest_byte
);

  localparam int IW = $clog2(MC + 1);
  localparam int CW = $clog2(MC);
  localparam int PW = $clog2(MC * 8);

  logic [9:0]          hash_bits;
  logic [MC-1:0][63:0] cv;
  logic [MC-1:0][63:0] bufw;
  logic [IW-1:0]       word_index;
  logic [63:0]         bit_count;
  logic [63:0]         last_data;
  logic [6:0]          last_v;
  logic [63:0]         msg_len;
  logic [MC-1:0][63:0] a;
  logic [MC-1:0][63:0] q;

  logic                wide;
  logic                cfg_large;
  logic [IW-1:0]       nc;
  logic [6:0]          v_c;
  logic [63:0]         pw;
  logic [2:0]          fb;
  logic [2:0]          eb;
  logic [MC-1:0][63:0] m;
  logic [MC-1:0][63:0] cv_init_small;
  logic [MC-1:0][63:0] cv_init_large;
  logic [MC-1:0][63:0] p_out;
  logic [MC-1:0][63:0] q_out;
  logic [6:0]          hb;
  logic [7:0]          nbytes;
  logic [7:0]          p;
  logic                two_blocks;

  assign wide      = hash_bits > kupyna_pkg::SMALL_LIMIT;
  assign cfg_large = cfg_wdata > kupyna_pkg::SMALL_LIMIT;
  assign nc        = wide ? IW'(MC) : IW'(kupyna_pkg::SMALL_COLUMNS);
  assign v_c       = (valid_bits > 7'd64) ? 7'd64 : valid_bits;
  assign fb        = last_v[5:3];
  assign eb        = last_v[2:0];

  always_comb begin
    cv_init_small    = '0;
    cv_init_large    = '0;
    cv_init_small[0] = 64'(kupyna_pkg::SMALL_COLUMNS * 8);
    cv_init_large[0] = 64'(MC * 8);
  end

  always_comb begin
    for (int n = 0; n < 8; n++) begin
      if (last_v[6] || (n < int'(fb))) begin
        pw[8*n +: 8] = last_data[8*n +: 8];
      end else if (n == int'(fb)) begin
        pw[8*n +: 8] = (last_data[8*n +: 8] & ~(8'hFF >> eb)) | (8'h80 >> eb);
      end else begin
        pw[8*n +: 8] = 8'd0;
      end
    end
  end

  assign two_blocks = (int'(word_index) * 64 + int'(last_v))
                    > (int'(nc) * 64 - kupyna_pkg::LEN_BITS);

  always_comb begin
    int g;
    int lenpos;
    lenpos = two_blocks ? (2 * int'(nc) - 2) : (int'(nc) - 2);
    for (int j = 0; j < MC; j++) begin
      g = cmd.blk ? (int'(nc) + j) : j;
      if (!cmd.pad) begin
        m[j] = bufw[j];
      end else begin
        m[j] = 64'd0;
        if (g < int'(word_index)) m[j] = bufw[j];
        if (g == int'(word_index)) m[j] = pw;
        if ((g == int'(word_index) + 1) && last_v[6]) m[j] = 64'h80;
        if (g == lenpos) m[j] = m[j] | {msg_len[31:0], 32'd0};
        if (g == lenpos + 1) m[j] = m[j] | {32'd0, msg_len[63:32]};
      end
    end
  end

  kupyna_round #(.MC(MC)) u_p (
    .s_in  (a),
    .wide  (wide),
    .use_q (1'b0),
    .rnd   (cmd.rnd),
    .s_out (p_out)
  );

  kupyna_round #(.MC(MC)) u_q (
    .s_in  (q),
    .wide  (wide),
    .use_q (1'b1),
    .rnd   (cmd.rnd),
    .s_out (q_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_bits  <= kupyna_pkg::HASH_BITS_RESET;
      cv         <= cv_init_small;
      word_index <= '0;
      bit_count  <= '0;
    end else if (cfg_wen) begin
      hash_bits  <= cfg_wdata;
      cv         <= cfg_large ? cv_init_large : cv_init_small;
      word_index <= '0;
      bit_count  <= '0;
    end else begin
      if (cmd.word_acc && !last_word) begin
        word_index <= word_index + IW'(1);
        bit_count  <= bit_count + 64'd64;
      end
      if (cmd.round && cmd.fold) begin
        cv <= cv ^ p_out ^ (cmd.use_q ? q_out : '0);
      end
      if (cmd.clr_index) begin
        word_index <= '0;
      end
      if (cmd.restart) begin
        cv         <= wide ? cv_init_large : cv_init_small;
        word_index <= '0;
        bit_count  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.word_acc) begin
      if (last_word) begin
        last_data <= data_word;
        last_v    <= v_c;
        msg_len   <= bit_count + {57'd0, v_c};
      end else begin
        bufw[word_index[CW-1:0]] <= data_word;
      end
    end
    if (cmd.load) begin
      a <= cv ^ m;
      q <= m;
    end else if (cmd.tload) begin
      a <= cv;
    end else if (cmd.round) begin
      a <= p_out;
      q <= q_out;
    end
  end

  always_comb begin
    if (hash_bits[9:3] == 7'd0) begin
      hb = 7'd1;
    end else if (hash_bits[9:3] > 7'd64) begin
      hb = 7'd64;
    end else begin
      hb = hash_bits[9:3];
    end
  end

  assign nbytes      = wide ? 8'(MC * 8) : 8'(kupyna_pkg::SMALL_COLUMNS * 8);
  assign p           = nbytes - {1'b0, hb} + {2'd0, cmd.byte_idx};
  assign digest_byte = cv[p[PW-1:3]][8*p[2:0] +: 8];

  assign status.wide       = wide;
  assign status.full       = (word_index + IW'(1)) == nc;
  assign status.two_blocks = two_blocks;
  assign status.hb         = hb;

endmodule

### rtl/kupyna_ctrl.sv
// Controller: word intake, round sequencing, output transform, digest emission.
module kupyna_ctrl #(
  parameter int MC = kupyna_pkg::MAX_COLUMNS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       last_word,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       last_byte,
  input  kupyna_pkg::kupyna_status_t status,
  output kupyna_pkg::kupyna_cmd_t    cmd
);

  localparam int BIG_ROUNDS = (MC == kupyna_pkg::SMALL_COLUMNS) ?
                              kupyna_pkg::SMALL_ROUNDS : kupyna_pkg::LARGE_ROUNDS;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOAD   = 6'b000010,
    S_ROUND  = 6'b000100,
    S_TLOAD  = 6'b001000,
    S_TROUND = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [3:0] rnd, rnd_next;
  logic       blk, blk_next;
  logic       pad, pad_next;
  logic [5:0] k, k_next;
  logic       in_acc;
  logic       rnd_last;
  logic       byte_last;

  assign in_stall  = state != S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = state == S_EMIT;
  assign rnd_last  = rnd == (status.wide ? 4'(BIG_ROUNDS - 1)
                                         : 4'(kupyna_pkg::SMALL_ROUNDS - 1));
  assign byte_last = ({1'b0, k} + 7'd1) == status.hb;
  assign last_byte = byte_last;

  always_comb begin
    state_next = state;
    rnd_next   = rnd;
    blk_next   = blk;
    pad_next   = pad;
    k_next     = k;
    cmd        = '0;
    cmd.rnd      = rnd;
    cmd.byte_idx = k;
    cmd.blk      = blk;
    cmd.pad      = pad;
    cmd.use_q    = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          cmd.word_acc = 1'b1;
          if (last_word || status.full) begin
            pad_next   = last_word;
            blk_next   = 1'b0;
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        rnd_next   = 4'd0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        cmd.fold  = rnd_last;
        rnd_next  = rnd + 4'd1;
        if (rnd_last) begin
          if (pad && !blk && status.two_blocks) begin
            blk_next   = 1'b1;
            state_next = S_LOAD;
          end else if (pad) begin
            state_next = S_TLOAD;
          end else begin
            cmd.clr_index = 1'b1;
            state_next    = S_IDLE;
          end
        end
      end
      S_TLOAD: begin
        cmd.tload  = 1'b1;
        rnd_next   = 4'd0;
        state_next = S_TROUND;
      end
      S_TROUND: begin
        cmd.round = 1'b1;
        cmd.use_q = 1'b0;
        cmd.fold  = rnd_last;
        rnd_next  = rnd + 4'd1;
        if (rnd_last) begin
          k_next     = 6'd0;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          k_next = k + 6'd1;
          if (byte_last) begin
            cmd.restart = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rnd   <= 4'd0;
      blk   <= 1'b0;
      pad   <= 1'b0;
      k     <= 6'd0;
    end else begin
      state <= state_next;
      rnd   <= rnd_next;
      blk   <= blk_next;
      pad   <= pad_next;
      k     <= k_next;
    end
  end

endmodule

### test/kupyna_hash_engine_checker.sv
// Checker for the hash engine: watches all channels, predicts digest bytes, compares.
module kupyna_hash_engine_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] data_word,
  input  logic [6:0]  valid_bits,
  input  logic        last_word,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  digest_byte,
  input  logic        last_byte,
  output int          errors,
  output int          pending
);

  typedef logic [63:0] state_t [kupyna_pkg::MAX_COLUMNS];
  typedef struct packed {
    logic [7:0] value;
    logic       final_flag;
  } digest_t;

  logic [9:0]  hash_len;
  state_t      chain;
  state_t      block_words;
  int          fill;
  logic [63:0] bit_count;
  digest_t     digest_q [$];

  function automatic int columns();
    return (hash_len <= kupyna_pkg::SMALL_LIMIT) ? kupyna_pkg::SMALL_COLUMNS
                                                 : kupyna_pkg::MAX_COLUMNS;
  endfunction

  function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1D : 8'h00);
    end
    return acc;
  endfunction

  function automatic void permute(inout state_t s, input int nc, input bit q_side);
    logic [7:0] b [kupyna_pkg::MAX_COLUMNS][8];
    logic [7:0] t [kupyna_pkg::MAX_COLUMNS];
    logic [7:0] acc;
    int rounds;
    int sh;
    rounds = (nc == kupyna_pkg::SMALL_COLUMNS) ? kupyna_pkg::SMALL_ROUNDS
                                               : kupyna_pkg::LARGE_ROUNDS;
    for (int r = 0; r < rounds; r++) begin
      for (int j = 0; j < nc; j++) begin
        if (q_side)
          s[j] = s[j] + (kupyna_pkg::Q_CONST ^ ({56'd0, 8'(((nc - j - 1) * 16) ^ r)} << 56));
        else
          s[j] = s[j] ^ {56'd0, 8'((j * 16) ^ r)};
      end
      for (int j = 0; j < nc; j++)
        for (int i = 0; i < 8; i++)
          b[j][i] = kupyna_pkg::SBOX[i % 4][s[j][8*i +: 8]];
      for (int i = 0; i < 8; i++) begin
        sh = (i == 7 && nc == 16) ? 11 : i;
        for (int j = 0; j < nc; j++) t[(j + sh) % nc] = b[j][i];
        for (int j = 0; j < nc; j++) b[j][i] = t[j];
      end
      for (int j = 0; j < nc; j++)
        for (int i = 0; i < 8; i++) begin
          acc = 8'd0;
          for (int k = 0; k < 8; k++)
            acc ^= field_mul(b[j][k], kupyna_pkg::MDS_ROW[(k + 8 - i) % 8]);
          s[j][8*i +: 8] = acc;
        end
    end
  endfunction

  function automatic void compress(input state_t m);
    state_t a;
    state_t q;
    int nc;
    nc = columns();
    a = chain;
    q = m;
    for (int j = 0; j < nc; j++) a[j] = chain[j] ^ m[j];
    permute(a, nc, 1'b0);
    permute(q, nc, 1'b1);
    for (int j = 0; j < nc; j++) chain[j] ^= a[j] ^ q[j];
  endfunction

  function automatic void restart();
    for (int j = 0; j < kupyna_pkg::MAX_COLUMNS; j++) begin
      chain[j] = 64'd0;
      block_words[j] = 64'd0;
    end
    chain[0] = 64'(columns() * 8);
    fill = 0;
    bit_count = 64'd0;
  endfunction

  function automatic void hash_word(input logic [63:0] data, input logic [6:0] vb,
                                    input logic fin);
    logic [63:0] padded [2*kupyna_pkg::MAX_COLUMNS];
    state_t      blk;
    state_t      t;
    logic [63:0] keep;
    logic [63:0] len;
    int nc, v, fb, eb, nblk, hb, first, p;
    digest_t d;
    nc = columns();
    if (fill >= nc) fill = 0;
    if (!fin) begin
      block_words[fill] = data;
      fill++;
      bit_count += 64;
      if (fill == nc) begin
        compress(block_words);
        fill = 0;
      end
      return;
    end
    v = (vb > 64) ? 64 : vb;
    for (int j = 0; j < 2*kupyna_pkg::MAX_COLUMNS; j++) padded[j] = 64'd0;
    for (int j = 0; j < fill; j++) padded[j] = block_words[j];
    if (v < 64) begin
      fb = v / 8;
      eb = v % 8;
      keep = (fb != 0) ? ((64'd1 << (8 * fb)) - 64'd1) : 64'd0;
      keep |= {56'd0, 8'(8'hFF << (8 - eb))} << (8 * fb);
      padded[fill] = (data & keep) | ({56'd0, 8'(8'h80 >> eb)} << (8 * fb));
    end else begin
      padded[fill] = data;
      padded[fill + 1] = 64'h80;
    end
    nblk = (fill * 64 + v <= nc * 64 - kupyna_pkg::LEN_BITS) ? 1 : 2;
    len = bit_count + 64'(v);
    padded[nblk * nc - 2] |= len << 32;
    padded[nblk * nc - 1] |= len >> 32;
    for (int n = 0; n < nblk; n++) begin
      blk = chain;
      for (int j = 0; j < nc; j++) blk[j] = padded[n * nc + j];
      compress(blk);
    end
    t = chain;
    permute(t, nc, 1'b0);
    for (int j = 0; j < nc; j++) chain[j] ^= t[j];
    hb = hash_len / 8;
    if (hb < 1) hb = 1;
    if (hb > 64) hb = 64;
    first = nc * 8 - hb;
    for (int k = 0; k < hb; k++) begin
      p = first + k;
      d.value = chain[p / 8][8 * (p % 8) +: 8];
      d.final_flag = (k + 1 == hb);
      digest_q.push_back(d);
    end
    restart();
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  initial errors = 0;
  initial pending = 0;

  always @(posedge clk) begin
    digest_t d;
    if (rst) begin
      hash_len = kupyna_pkg::HASH_BITS_RESET;
      restart();
      digest_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("unexpected digest byte %02h", digest_byte));
        end else begin
          d = digest_q.pop_front();
          if (digest_byte !== d.value)
            report_mismatch($sformatf("digest_byte %02h, want %02h", digest_byte, d.value));
          if (last_byte !== d.final_flag)
            report_mismatch($sformatf("last_byte %b, want %b", last_byte, d.final_flag));
        end
      end
      if (cfg_wen) begin
        hash_len = cfg_wdata;
        restart();
      end
      if (in_valid && !in_stall) hash_word(data_word, valid_bits, last_word);
    end
    pending = digest_q.size();
  end
endmodule

### test/kupyna_hash_engine_tb.sv
// Testbench top for the hash engine: clock, reset, word stimulus and verdict.
module kupyna_hash_engine_tb;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEM_TARGET = 330;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [9:0]  cfg_wdata = 10'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] data_word = 64'd0;
  logic [6:0]  valid_bits = 7'd0;
  logic        last_word = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  digest_byte;
  logic        last_byte;
  int          errors;
  int          pending;
  int          words_sent = 0;
  int          idle_cycles = 0;
  bit          steady = 1'b0;
  int          stall_phase = 0;

  always #10 clk = ~clk;

  kupyna_hash_engine DUT (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .data_word(data_word),
    .valid_bits(valid_bits), .last_word(last_word), .out_valid(out_valid),
    .out_stall(out_stall), .digest_byte(digest_byte), .last_byte(last_byte)
  );

  kupyna_hash_engine_checker u_checker (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .data_word(data_word),
    .valid_bits(valid_bits), .last_word(last_word), .out_valid(out_valid),
    .out_stall(out_stall), .digest_byte(digest_byte), .last_byte(last_byte),
    .errors(errors), .pending(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // stall the digest side in alternating phases: none, light, heavy
  always @(negedge clk) begin
    stall_phase <= (stall_phase + 1) % 600;
    if (stall_phase < 150) out_stall <= 1'b0;
    else if (stall_phase < 450) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** kupyna_hash_engine: FAILED **");
      $finish;
    end
  end

  task automatic send_word(input logic [63:0] d, input logic [6:0] vb, input logic fin);
    int gap;
    gap = steady ? 0 : gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    data_word = d;
    valid_bits = vb;
    last_word = fin;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int body_words, input logic [6:0] tail_bits,
                              input bit ones);
    logic [63:0] d;
    steady = ($urandom_range(0, 9) < 3);
    for (int i = 0; i <= body_words; i++) begin
      d = ones ? '1 : {$urandom(), $urandom()};
      if (i < body_words) send_word(d, 7'($urandom_range(0, 127)), 1'b0);
      else send_word(d, tail_bits, 1'b1);
    end
    in_valid = 1'b0;
  endtask

  task automatic write_hash_len(input logic [9:0] value);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_wen = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wen = 1'b0;
  endtask

  initial begin
    logic [9:0] lens [14] = '{10'd0, 10'd1, 10'd7, 10'd8, 10'd16, 10'd248, 10'd256,
                              10'd257, 10'd264, 10'd384, 10'd504, 10'd512, 10'd520,
                              10'd1023};
    int nc;
    logic [6:0] tail;
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: empty, full, partial, padding spill, oversize bit count
    send_message(0, 7'd0, 1'b0);
    send_message(0, 7'd64, 1'b1);
    send_message(0, 7'd63, 1'b1);
    send_message(0, 7'd1, 1'b0);
    send_message(6, 7'd64, 1'b0);
    send_message(7, 7'd127, 1'b1);
    send_message(8, 7'd30, 1'b0);
    write_hash_len(10'd1023);
    send_message(14, 7'd32, 1'b1);
    send_message(2, 7'd64, 1'b0);
    write_hash_len(10'd0);
    send_message(1, 7'd7, 1'b1);
    write_hash_len(10'd512);
    send_message(0, 7'd100, 1'b0);

    while (words_sent < ITEM_TARGET) begin
      write_hash_len(($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                 : lens[$urandom_range(0, 13)]);
      nc = (u_checker.hash_len <= 10'd256) ? 8 : 16;
      repeat ($urandom_range(2, 6)) begin
        tail = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(65, 127))
                                          : 7'($urandom_range(0, 64));
        if ($urandom_range(0, 7) == 0)
          send_message($urandom_range(nc, 2 * nc + 3), tail, 1'b0);
        else
          send_message($urandom_range(0, nc + 2), tail, 1'b0);
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0)
      $display("** kupyna_hash_engine: PASSED **");
    else
      $display("** kupyna_hash_engine: FAILED **");
    $finish;
  end
endmodule
